FILE: hw/rtl/blit_pkg.sv
package blit_pkg;

    // field widths
    localparam int WEIGHT_W = 21;
    localparam int TIME_W   = 32;
    localparam int INTAKE_W = 32;
    localparam int LIFT_W   = 20;
    localparam int MARGIN_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    // stream word widths
    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 104;

    // configuration register reset values, and the capacity reset value
    localparam logic [LIFT_W-1:0]   LIFT_RST   = 20'd500;
    localparam logic [MARGIN_W-1:0] DELAY_RST  = 16'd2000;
    localparam logic [MARGIN_W-1:0] HOLD_RST   = 16'd50;
    localparam logic [MARGIN_W-1:0] NOISE_RST  = 16'd100;
    localparam logic signed [WEIGHT_W-1:0] CAPACITY_RST = 21'sd5000;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LIFT  = 2'd0,
        CFG_DELAY = 2'd1,
        CFG_HOLD  = 2'd2,
        CFG_NOISE = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_CAL    = 2'd1,
        KIND_REFILL = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        MODE_SETUP   = 2'd0,
        MODE_IDLE    = 2'd1,
        MODE_REMOVED = 2'd2,
        MODE_SETTLE  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_REMOVED   = 3'd1,
        EV_PLACED    = 3'd2,
        EV_INTAKE    = 3'd3,
        EV_NEGATIVE  = 3'd4,
        EV_SMALL     = 3'd5,
        EV_CAL_OK    = 3'd6,
        EV_CAL_FAIL  = 3'd7
    } event_t;

    typedef struct packed {
        logic [LIFT_W-1:0]   lift_level;
        logic [MARGIN_W-1:0] stabilize_delay_ms;
        logic [MARGIN_W-1:0] hold_margin;
        logic [MARGIN_W-1:0] noise_margin;
    } cfg_t;

    typedef struct packed {
        logic [1:0]                  kind;
        logic signed [WEIGHT_W-1:0]  weight;
        logic [TIME_W-1:0]           now_ms;
        logic                        sensor_error;
    } item_t;

    typedef struct packed {
        mode_t                       mode;
        logic signed [WEIGHT_W-1:0]  baseline;
        logic signed [WEIGHT_W-1:0]  capacity;
        logic [INTAKE_W-1:0]         intake;
        logic [TIME_W-1:0]           settle_start;
        logic signed [WEIGHT_W-1:0]  last_weight;
    } trk_state_t;

endpackage

FILE: hw/rtl/blit_cfg_regs.sv
module blit_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [blit_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [blit_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output blit_pkg::cfg_t                    cfg
);
    import blit_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // register write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_index))
                CFG_LIFT:  cfg_next.lift_level         = cfg_wdata[LIFT_W-1:0];
                CFG_DELAY: cfg_next.stabilize_delay_ms = cfg_wdata[MARGIN_W-1:0];
                CFG_HOLD:  cfg_next.hold_margin        = cfg_wdata[MARGIN_W-1:0];
                CFG_NOISE: cfg_next.noise_margin       = cfg_wdata[MARGIN_W-1:0];
                default:   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.lift_level         <= LIFT_RST;
            cfg_reg.stabilize_delay_ms <= DELAY_RST;
            cfg_reg.hold_margin        <= HOLD_RST;
            cfg_reg.noise_margin       <= NOISE_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hw/rtl/blit_step.sv
module blit_step (
    input  blit_pkg::cfg_t       cfg,
    input  blit_pkg::item_t      item,
    input  blit_pkg::trk_state_t st,
    output blit_pkg::trk_state_t st_next,
    output blit_pkg::event_t     ev
);
    import blit_pkg::*;

    logic signed [WEIGHT_W:0]   w_ext;
    logic signed [WEIGHT_W:0]   thr_ext;
    logic signed [WEIGHT_W+1:0] base_floor;
    logic signed [WEIGHT_W+1:0] w_wide;
    logic signed [WEIGHT_W+1:0] used;
    logic signed [WEIGHT_W+1:0] noise_pos;
    logic signed [WEIGHT_W+1:0] noise_neg;
    logic [TIME_W-1:0]          elapsed;
    logic                       settle_done;
    logic [INTAKE_W:0]          sum;
    logic [INTAKE_W-1:0]        sum_sat;

    // compares and differences, widened by sign or zero extension
    always_comb begin
        w_ext      = {item.weight[WEIGHT_W-1], item.weight};
        thr_ext    = signed'({2'b0, cfg.lift_level});
        w_wide     = {{2{item.weight[WEIGHT_W-1]}}, item.weight};
        base_floor = {{2{st.baseline[WEIGHT_W-1]}}, st.baseline}
                     - signed'({7'b0, cfg.hold_margin});
        used       = {{2{st.baseline[WEIGHT_W-1]}}, st.baseline} - w_wide;
        noise_pos  = signed'({7'b0, cfg.noise_margin});
        noise_neg  = -noise_pos;
        elapsed    = item.now_ms - st.settle_start;
        settle_done = elapsed >= {16'b0, cfg.stabilize_delay_ms};
        sum        = {1'b0, st.intake} + {12'b0, used[WEIGHT_W-1:0]};
        sum_sat    = sum[INTAKE_W] ? {INTAKE_W{1'b1}} : sum[INTAKE_W-1:0];
    end

    // mode transitions and state updates
    always_comb begin
        st_next = st;
        ev      = EV_NONE;
        case (kind_t'(item.kind))
            KIND_SAMPLE: begin
                st_next.last_weight = item.weight;
                case (st.mode)
                    MODE_IDLE: begin
                        if (w_ext < thr_ext) begin
                            st_next.mode = MODE_REMOVED;
                            ev = EV_REMOVED;
                        end else if (w_wide > base_floor) begin
                            st_next.baseline = item.weight;
                        end
                    end
                    MODE_REMOVED: begin
                        if (w_ext > thr_ext) begin
                            st_next.settle_start = item.now_ms;
                            st_next.mode = MODE_SETTLE;
                            ev = EV_PLACED;
                        end
                    end
                    MODE_SETTLE: begin
                        if (settle_done) begin
                            if (used > noise_pos) begin
                                st_next.intake = sum_sat;
                                ev = EV_INTAKE;
                            end else if (used < noise_neg) begin
                                ev = EV_NEGATIVE;
                            end else begin
                                ev = EV_SMALL;
                            end
                            st_next.mode = MODE_IDLE;
                        end
                    end
                    default: begin
                        st_next.mode = st.mode;
                    end
                endcase
            end
            KIND_CAL: begin
                if (item.sensor_error) begin
                    ev = EV_CAL_FAIL;
                end else begin
                    st_next.last_weight = item.weight;
                    st_next.capacity    = item.weight;
                    st_next.baseline    = item.weight;
                    st_next.mode        = MODE_IDLE;
                    ev = EV_CAL_OK;
                end
            end
            KIND_REFILL: begin
                st_next.last_weight = item.weight;
                st_next.capacity    = item.weight;
                st_next.baseline    = item.weight;
                st_next.mode        = MODE_IDLE;
            end
            default: begin
                ev = EV_NONE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/bottle_lift_intake_tracker_unit.sv
// Bottle lift intake tracker. Takes one word per clock while m_tready
// does not stall the result stream: weight samples, calibrate and refill
// events, selected by s_tuser. Each word gives exactly one result word
// with the mode after the word, the event it caused and the tracked
// weights and saturating daily intake. A word passes an input register,
// then a single pass of compare/subtract/add logic that updates the
// tracking state and loads the result register. The input register holds
// its word while the result register holds a word that m_tready does not
// take. Configuration registers take effect for words processed after the
// write and must be written only while no word is in flight.
module bottle_lift_intake_tracker_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write port
    input  logic                              cfg_wr_en,
    input  logic [blit_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [blit_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // weight [20:0], now_ms [52:21], sensor_error [53], zero [55:54]
    input  logic [blit_pkg::S_TDATA_W-1:0]    s_tdata,
    // kind [1:0]
    input  logic [blit_pkg::S_TUSER_W-1:0]    s_tuser,
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // mode [1:0], event_res [4:2], daily_intake [36:5],
    // baseline_weight [57:37], capacity_weight [78:58],
    // last_weight [99:79], zero [103:100]
    output logic [blit_pkg::M_TDATA_W-1:0]    m_tdata
);
    import blit_pkg::*;

    cfg_t        cfg;
    item_t       in_item_reg;
    logic        in_valid_reg;
    logic        in_valid_next;
    trk_state_t  st_reg;
    trk_state_t  st_next;
    event_t      ev;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic        out_free;
    logic        advance;
    logic        load_in;

    blit_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    blit_step u_step (
        .cfg     (cfg),
        .item    (in_item_reg),
        .st      (st_reg),
        .st_next (st_next),
        .ev      (ev)
    );

    // pipeline flow control
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign load_in  = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (load_in) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input word register
    always_ff @(posedge aclk) begin
        if (load_in) begin
            in_item_reg.kind         <= s_tuser;
            in_item_reg.weight       <= s_tdata[20:0];
            in_item_reg.now_ms       <= s_tdata[52:21];
            in_item_reg.sensor_error <= s_tdata[53];
        end
    end

    // tracking state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.mode         <= MODE_SETUP;
            st_reg.baseline     <= '0;
            st_reg.capacity     <= CAPACITY_RST;
            st_reg.intake       <= '0;
            st_reg.settle_start <= '0;
            st_reg.last_weight  <= '0;
        end else if (advance) begin
            st_reg <= st_next;
        end
    end

    // result word register
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {4'b0, st_next.last_weight, st_next.capacity,
                             st_next.baseline, st_next.intake, ev, st_next.mode};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

FILE: hw/rtl/blit_checker.sv
module blit_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [blit_pkg::M_TDATA_W-1:0]    m_tdata
);
    import blit_pkg::*;

    // stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // no result word right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word valid after reset");

    // a lift event leaves the block in removed mode
    a_removed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[4:2] == EV_REMOVED |-> m_tdata[1:0] == MODE_REMOVED)
        else $error("removed event without removed mode");

    // calibration sets idle and all three weights equal
    a_cal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[4:2] == EV_CAL_OK |->
            m_tdata[1:0] == MODE_IDLE && m_tdata[57:37] == m_tdata[78:58]
            && m_tdata[78:58] == m_tdata[99:79])
        else $error("calibration result inconsistent");

endmodule

bind bottle_lift_intake_tracker_unit blit_checker u_blit_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: verif/bottle_lift_intake_tracker_unit_test.sv
`timescale 1ns / 1ps

module bottle_lift_intake_tracker_unit_test;
    import blit_pkg::*;

    // kind code the block has to ignore
    localparam logic [1:0] KIND_UNKNOWN = 2'd3;

    localparam int RAND_PHASES    = 8;
    localparam int PHASE_WORDS    = 110;
    localparam int SAT_ROUNDS     = 50;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam longint INTAKE_CAP = 64'h0000_0000_FFFF_FFFF;

    // result word field positions
    localparam int MODE_LSB   = 0;
    localparam int EV_LSB     = 2;
    localparam int INTAKE_LSB = 5;
    localparam int BASE_LSB   = 37;
    localparam int CAP_LSB    = 58;
    localparam int LAST_LSB   = 79;

    typedef struct {
        mode_t                      mode;
        event_t                     ev;
        logic [INTAKE_W-1:0]        intake;
        logic signed [WEIGHT_W-1:0] baseline;
        logic signed [WEIGHT_W-1:0] capacity;
        logic signed [WEIGHT_W-1:0] last_weight;
    } status_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [S_TUSER_W-1:0]  s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    bottle_lift_intake_tracker_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    // words waiting to be sent and tracker status words still due
    item_t   scale_words[$];
    status_t status_due[$];
    item_t   offer;

    int  err_cnt     = 0;
    int  words_out   = 0;
    int  words_queued = 0;
    bit  quiet_mode  = 1'b0;

    // tracker copy of the configuration
    logic [LIFT_W-1:0]   cfg_lift  = LIFT_RST;
    logic [MARGIN_W-1:0] cfg_delay = DELAY_RST;
    logic [MARGIN_W-1:0] cfg_hold  = HOLD_RST;
    logic [MARGIN_W-1:0] cfg_noise = NOISE_RST;

    // tracker copy of the state
    mode_t                      trk_mode;
    logic signed [WEIGHT_W-1:0] trk_base;
    logic signed [WEIGHT_W-1:0] trk_cap;
    logic signed [WEIGHT_W-1:0] trk_last;
    logic [INTAKE_W-1:0]        trk_intake;
    logic [TIME_W-1:0]          trk_settle_t0;

    // stimulus generator view of the bottle
    longint            g_bottle;
    logic [TIME_W-1:0] g_now;

    // idle length, mostly short and now and then long
    function automatic int pick_gap();
        int r;
        if (quiet_mode) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        err_cnt++;
        if (err_cnt <= 100)
            $display("mismatch %s at result %0d: got %0h, expected %0h",
                     what, words_out, got, want);
    endtask

    // tracker update for one accepted word, queues the status it causes
    task automatic track_bottle(input item_t it);
        longint            w, thr, base_l, hold_l, noise_l, used, sum;
        logic [TIME_W-1:0] waited;
        event_t            ev;
        status_t           st;
        w       = longint'(it.weight);
        thr     = longint'(cfg_lift);
        hold_l  = longint'(cfg_hold);
        noise_l = longint'(cfg_noise);
        ev      = EV_NONE;
        case (it.kind)
            KIND_SAMPLE: begin
                trk_last = it.weight;
                base_l   = longint'(trk_base);
                case (trk_mode)
                    MODE_IDLE: begin
                        if (w < thr) begin
                            trk_mode = MODE_REMOVED;
                            ev       = EV_REMOVED;
                        end else if (w > base_l - hold_l) begin
                            trk_base = it.weight;
                        end
                    end
                    MODE_REMOVED: begin
                        if (w > thr) begin
                            trk_settle_t0 = it.now_ms;
                            trk_mode      = MODE_SETTLE;
                            ev            = EV_PLACED;
                        end
                    end
                    MODE_SETTLE: begin
                        waited = it.now_ms - trk_settle_t0;
                        if (waited >= cfg_delay) begin
                            used = base_l - w;
                            if (used > noise_l) begin
                                sum = longint'(trk_intake);
                                sum = sum + used;
                                trk_intake = (sum > INTAKE_CAP) ? '1 : sum[31:0];
                                ev = EV_INTAKE;
                            end else if (used < -noise_l) begin
                                ev = EV_NEGATIVE;
                            end else begin
                                ev = EV_SMALL;
                            end
                            trk_mode = MODE_IDLE;
                        end
                    end
                    default: ;
                endcase
            end
            KIND_CAL: begin
                if (it.sensor_error) begin
                    ev = EV_CAL_FAIL;
                end else begin
                    trk_last = it.weight;
                    trk_cap  = it.weight;
                    trk_base = it.weight;
                    trk_mode = MODE_IDLE;
                    ev       = EV_CAL_OK;
                end
            end
            KIND_REFILL: begin
                trk_last = it.weight;
                trk_cap  = it.weight;
                trk_base = it.weight;
                trk_mode = MODE_IDLE;
            end
            default: ;
        endcase
        st.mode        = trk_mode;
        st.ev          = ev;
        st.intake      = trk_intake;
        st.baseline    = trk_base;
        st.capacity    = trk_cap;
        st.last_weight = trk_last;
        status_due.push_back(st);
    endtask

    // sender: offers queued words, predicts each one as it is taken
    always @(posedge aclk) begin : drive_proc
        logic busy;
        int   send_gap;
        if (!aresetn) begin
            s_tvalid      <= 1'b0;
            send_gap      = 0;
            trk_mode      = MODE_SETUP;
            trk_base      = '0;
            trk_cap       = CAPACITY_RST;
            trk_last      = '0;
            trk_intake    = '0;
            trk_settle_t0 = '0;
        end else begin
            busy = s_tvalid && !s_tready;
            if (s_tvalid && s_tready) begin
                track_bottle(offer);
                send_gap = pick_gap();
            end
            if (!busy) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (scale_words.size() > 0) begin
                    offer = scale_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {2'b00, offer.sensor_error, offer.now_ms, offer.weight};
                    s_tuser  <= offer.kind;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each status word, stalls at random and twice for long
    always @(posedge aclk) begin : check_proc
        status_t want;
        int      recv_gap;
        int      long_hold;
        if (!aresetn) begin
            m_tready  <= 1'b0;
            recv_gap  = 0;
            long_hold = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                words_out++;
                if (status_due.size() == 0) begin
                    report_mismatch("unexpected word", m_tdata[31:0], 32'd0);
                end else begin
                    want = status_due.pop_front();
                    if (m_tdata[MODE_LSB +: 2] !== want.mode)
                        report_mismatch("mode", {30'd0, m_tdata[MODE_LSB +: 2]},
                                        {30'd0, want.mode});
                    if (m_tdata[EV_LSB +: 3] !== want.ev)
                        report_mismatch("event", {29'd0, m_tdata[EV_LSB +: 3]},
                                        {29'd0, want.ev});
                    if (m_tdata[INTAKE_LSB +: INTAKE_W] !== want.intake)
                        report_mismatch("daily_intake", m_tdata[INTAKE_LSB +: INTAKE_W],
                                        want.intake);
                    if (m_tdata[BASE_LSB +: WEIGHT_W] !== want.baseline)
                        report_mismatch("baseline", {11'd0, m_tdata[BASE_LSB +: WEIGHT_W]},
                                        {11'd0, want.baseline});
                    if (m_tdata[CAP_LSB +: WEIGHT_W] !== want.capacity)
                        report_mismatch("capacity", {11'd0, m_tdata[CAP_LSB +: WEIGHT_W]},
                                        {11'd0, want.capacity});
                    if (m_tdata[LAST_LSB +: WEIGHT_W] !== want.last_weight)
                        report_mismatch("last_weight", {11'd0, m_tdata[LAST_LSB +: WEIGHT_W]},
                                        {11'd0, want.last_weight});
                end
                if (words_out == 200 || words_out == 800)
                    long_hold = LONG_HOLD;
                else
                    recv_gap = pick_gap();
            end
            if (long_hold > 0) begin
                long_hold--;
                m_tready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin : watchdog_proc
        int idle_cycles;
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic queue_word(input logic [1:0] kind, input longint w,
                              input logic [TIME_W-1:0] now, input bit err);
        item_t it;
        it.kind         = kind;
        it.weight       = w[WEIGHT_W-1:0];
        it.now_ms       = now;
        it.sensor_error = err;
        scale_words.push_back(it);
        words_queued++;
    endtask

    // all registers in index order, only while nothing is in flight
    task automatic set_config(input logic [LIFT_W-1:0] lift,
                              input logic [MARGIN_W-1:0] delay_ms,
                              input logic [MARGIN_W-1:0] hold,
                              input logic [MARGIN_W-1:0] noise);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_LIFT;
        cfg_wdata <= lift;
        @(posedge aclk);
        cfg_index <= CFG_DELAY;
        cfg_wdata <= {4'd0, delay_ms};
        @(posedge aclk);
        cfg_index <= CFG_HOLD;
        cfg_wdata <= {4'd0, hold};
        @(posedge aclk);
        cfg_index <= CFG_NOISE;
        cfg_wdata <= {4'd0, noise};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cfg_lift  = lift;
        cfg_delay = delay_ms;
        cfg_hold  = hold;
        cfg_noise = noise;
    endtask

    task automatic wait_idle();
        do @(posedge aclk);
        while (scale_words.size() != 0 || s_tvalid || status_due.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    // one lift: idle jitter, removal, placing back, settling, settled reading, maybe refill
    task automatic drink_cycle();
        longint            lift_l, noise_l, drink;
        logic [TIME_W-1:0] t_place;
        lift_l  = longint'(cfg_lift);
        noise_l = longint'(cfg_noise);
        repeat ($urandom_range(0, 3)) begin
            g_now += $urandom_range(0, 400);
            queue_word(KIND_SAMPLE, g_bottle + $urandom_range(0, 60)
                       - $urandom_range(0, cfg_hold + 30), g_now, 1'($urandom_range(0, 1)));
        end
        g_now += $urandom_range(1, 400);
        queue_word(KIND_SAMPLE, lift_l - 1 - $urandom_range(0, 400), g_now, 1'b0);
        repeat ($urandom_range(0, 2)) begin
            g_now += $urandom_range(0, 3000);
            queue_word(KIND_SAMPLE, lift_l - $urandom_range(0, 5000), g_now, 1'b0);
        end
        g_now += $urandom_range(1, 2000);
        t_place = g_now;
        queue_word(KIND_SAMPLE, lift_l + 1 + $urandom_range(0, 3000), g_now, 1'b0);
        if (cfg_delay > 1) begin
            repeat ($urandom_range(0, 2)) begin
                g_now = t_place + $urandom_range(0, cfg_delay - 1);
                queue_word(KIND_SAMPLE, g_bottle - $urandom_range(0, 500), g_now, 1'b0);
            end
        end
        g_now = t_place + cfg_delay + (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 500));
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: drink = noise_l + 1 + $urandom_range(0, 4000);
            6, 7:             drink = -(noise_l + 1 + $urandom_range(0, 2000));
            8:                drink = ($urandom_range(0, 1) == 1) ? noise_l : -noise_l;
            default:          drink = $urandom_range(0, 2 * cfg_noise) - noise_l;
        endcase
        queue_word(KIND_SAMPLE, g_bottle - drink, g_now, 1'b0);
        if (drink > 0) g_bottle -= drink;
        // bottle running low, fill it up again
        if (g_bottle < lift_l + 2000) begin
            g_bottle = lift_l + $urandom_range(3000, 20000);
            g_now += $urandom_range(0, 1000);
            queue_word(KIND_REFILL, g_bottle, g_now, 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin : stimulus
        int   phase;
        int   phase_start;
        int   r;
        logic [LIFT_W-1:0]   lift;
        logic [MARGIN_W-1:0] delay_ms, hold, noise;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed words under the reset configuration
        queue_word(KIND_SAMPLE,  1234,     32'd100, 1'b0);  // setup mode sample
        queue_word(KIND_UNKNOWN, 777,      32'd110, 1'b1);  // ignored kind
        queue_word(KIND_CAL,     7000,     32'd120, 1'b1);  // calibrate refused
        queue_word(KIND_CAL,     6000,     32'd130, 1'b0);
        queue_word(KIND_SAMPLE,  6020,     32'd140, 1'b0);
        queue_word(KIND_SAMPLE,  5990,     32'd150, 1'b0);  // small drop follows
        queue_word(KIND_SAMPLE,  5900,     32'd160, 1'b0);  // large drop holds
        queue_word(KIND_SAMPLE,  5940,     32'd170, 1'b0);  // exactly hold margin
        queue_word(KIND_SAMPLE,  500,      32'd180, 1'b0);  // exactly at threshold
        queue_word(KIND_SAMPLE,  1048575,  32'd190, 1'b0);
        queue_word(KIND_SAMPLE,  499,      32'd200, 1'b0);  // lifted
        queue_word(KIND_SAMPLE,  -1048576, 32'd210, 1'b0);
        queue_word(KIND_SAMPLE,  500,      32'd220, 1'b0);
        queue_word(KIND_SAMPLE,  501,      32'hFFFF_FF00, 1'b0);  // placed near wrap
        queue_word(KIND_SAMPLE,  0,        32'h0000_0100, 1'b0);  // still settling
        queue_word(KIND_SAMPLE,  -1000,    32'h0000_06D0, 1'b0);  // delay just met
        queue_word(KIND_REFILL,  3000,     32'h0000_1000, 1'b1);
        queue_word(KIND_SAMPLE,  200,      32'h0000_1100, 1'b0);
        queue_word(KIND_SAMPLE,  6000,     32'h0000_2000, 1'b0);
        queue_word(KIND_SAMPLE,  6000,     32'h0000_27CF, 1'b0);
        queue_word(KIND_SAMPLE,  3100,     32'h0000_27D0, 1'b0);  // small at the margin
        queue_word(KIND_SAMPLE,  100,      32'h0000_3000, 1'b0);
        queue_word(KIND_SAMPLE,  900,      32'h0000_3100, 1'b0);
        queue_word(KIND_SAMPLE,  3101,     32'h0000_5000, 1'b0);  // negative, past margin
        queue_word(KIND_CAL,     -1048576, 32'h0000_5100, 1'b1);
        queue_word(KIND_REFILL,  -1048576, 32'h0000_5200, 1'b0);
        wait_idle();

        // back to back lifts with the largest possible drinks, no gaps
        set_config('0, '0, '0, '0);
        quiet_mode = 1'b1;
        queue_word(KIND_CAL, 1048575, 32'd0, 1'b0);
        for (int i = 0; i < SAT_ROUNDS; i++) begin
            queue_word(KIND_SAMPLE, -1,       i, 1'b0);
            queue_word(KIND_SAMPLE, 1,        i, 1'b0);
            queue_word(KIND_SAMPLE, -1048576, i, 1'b0);
        end
        wait_idle();
        quiet_mode = 1'b0;

        // random phases, each under its own setting
        g_now = $urandom;
        for (phase = 0; phase < RAND_PHASES; phase++) begin
            case (phase)
                0: begin
                    lift = LIFT_RST; delay_ms = DELAY_RST; hold = HOLD_RST; noise = NOISE_RST;
                end
                1: begin
                    lift = '1; delay_ms = '1; hold = '1; noise = '1;
                end
                2: begin
                    lift = '0; delay_ms = '0; hold = '0; noise = '0;
                end
                default: begin
                    lift     = ($urandom_range(0, 3) == 0) ? LIFT_W'($urandom)
                                                           : LIFT_W'($urandom_range(0, 20000));
                    delay_ms = ($urandom_range(0, 1) == 0) ? MARGIN_W'($urandom)
                                                           : MARGIN_W'($urandom_range(0, 3000));
                    hold     = ($urandom_range(0, 3) == 0) ? MARGIN_W'($urandom)
                                                           : MARGIN_W'($urandom_range(0, 300));
                    noise    = ($urandom_range(0, 3) == 0) ? MARGIN_W'($urandom)
                                                           : MARGIN_W'($urandom_range(0, 300));
                end
            endcase
            set_config(lift, delay_ms, hold, noise);
            quiet_mode = (phase == 3);
            if (phase == 4) g_now = 32'hFFFF_F000;
            g_bottle = longint'(cfg_lift) + $urandom_range(3000, 20000);
            queue_word(KIND_CAL, g_bottle, g_now, 1'b0);
            phase_start = words_queued;
            while (words_queued - phase_start < PHASE_WORDS) begin
                r = $urandom_range(0, 99);
                if (r < 15) begin
                    // noise: any kind, any reading, any time
                    queue_word(2'($urandom_range(0, 3)), $urandom, $urandom,
                               1'($urandom_range(0, 1)));
                end else if (r < 22) begin
                    g_bottle = longint'(cfg_lift) + $urandom_range(3000, 20000);
                    g_now += $urandom_range(0, 1000);
                    queue_word(($urandom_range(0, 1) == 1) ? KIND_CAL : KIND_REFILL,
                               g_bottle, g_now, $urandom_range(0, 3) == 0);
                end else begin
                    drink_cycle();
                end
            end
            wait_idle();
        end

        repeat (10) @(posedge aclk);
        if (status_due.size() != 0)
            report_mismatch("missing words", status_due.size(), 32'd0);
        if (err_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/blit_pkg.sv
hw/rtl/blit_cfg_regs.sv
hw/rtl/blit_step.sv
hw/rtl/bottle_lift_intake_tracker_unit.sv
hw/rtl/blit_checker.sv
verif/bottle_lift_intake_tracker_unit_test.sv
